FILE: src/brfr_pkg.sv
package brfr_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_FILL     = 2'd0,
    CMD_ROT_ROW  = 2'd1,
    CMD_ROT_COL  = 2'd2,
    CMD_READ_ROW = 2'd3
  } cmd_t;

  // fixed field widths
  localparam int SIZE_W      = 6;
  localparam int DIST_W      = 8;
  localparam int ROW_BITS_W  = 50;
  localparam int LIT_W       = 9;
  localparam int DIST_VALUES = 1 << DIST_W;

  localparam logic [LIT_W-1:0] LIT_MAX = '1;

  // residue table: distance reduced by a row or column length
  typedef logic [DIST_VALUES-1:0][SIZE_W-1:0] mod_tab_t;

  // one command as held in the input register
  typedef struct packed {
    cmd_t                command;
    logic [SIZE_W-1:0]   rect_width;
    logic [SIZE_W-1:0]   rect_height;
    logic [SIZE_W-1:0]   target_index;
    logic [DIST_W-1:0]   distance;
  } item_t;

  // result fields travelling down the pipeline beside the pixel state
  typedef struct packed {
    logic                  valid;
    logic                  err;
    logic [ROW_BITS_W-1:0] row_bits;
  } tag_t;

  // built at elaboration by counting, wraps at the modulus
  function automatic mod_tab_t mod_table(input int unsigned modulus);
    mod_tab_t    tab;
    int unsigned rem;
    rem = 0;
    for (int i = 0; i < DIST_VALUES; i++) begin
      tab[i] = SIZE_W'(rem);
      rem    = (rem + 1 == modulus) ? 0 : rem + 1;
    end
    return tab;
  endfunction

endpackage

FILE: src/brfr_exec.sv
module brfr_exec #(
  parameter int COLUMNS = 50,
  parameter int ROWS    = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          item_valid,
  input  brfr_pkg::item_t               item,
  output logic [ROWS-1:0][COLUMNS-1:0]  pixel_rows,
  output brfr_pkg::tag_t                tag
);
  import brfr_pkg::*;

  localparam int IDX_EXT_W = SIZE_W + 1;
  localparam int EXT_W     = (COLUMNS > ROW_BITS_W) ? COLUMNS : ROW_BITS_W;

  localparam logic [IDX_EXT_W-1:0] ROWS_LIM = IDX_EXT_W'(ROWS);
  localparam logic [IDX_EXT_W-1:0] COLS_LIM = IDX_EXT_W'(COLUMNS);
  localparam logic [COLUMNS-1:0]   FULL     = '1;
  localparam logic [COLUMNS-1:0]   COL_MSB  = COLUMNS'(1) << (COLUMNS - 1);
  localparam mod_tab_t             COL_MOD  = mod_table(COLUMNS);
  localparam mod_tab_t             ROW_MOD  = mod_table(ROWS);

  logic                         en;
  logic                         row_ok;
  logic                         col_ok;
  logic [ROWS-1:0]              row_sel;
  logic [COLUMNS-1:0]           sel_row;
  logic [COLUMNS-1:0]           rot_row;
  logic [COLUMNS-1:0]           span;
  logic [COLUMNS-1:0]           col_mask;
  logic [2*COLUMNS-1:0]         row_dbl;
  logic [SIZE_W-1:0]            col_dist;
  logic [SIZE_W-1:0]            row_dist;
  logic [ROWS-1:0]              col_vec;
  logic [ROWS-1:0]              col_rot;
  logic [2*ROWS-1:0]            col_dbl;
  logic [ROWS-1:0][COLUMNS-1:0] rows_next;
  logic [EXT_W-1:0]             read_ext;
  logic                         err_next;
  logic [ROW_BITS_W-1:0]        bits_next;
  logic                         tag_valid;
  logic                         tag_err;
  logic [ROW_BITS_W-1:0]        tag_bits;

  assign en = advance & item_valid;

  // index range checks and reduced distances
  assign row_ok   = {1'b0, item.target_index} < ROWS_LIM;
  assign col_ok   = {1'b0, item.target_index} < COLS_LIM;
  assign col_dist = COL_MOD[item.distance];
  assign row_dist = ROW_MOD[item.distance];

  // selected row, zero when the index is out of range
  always_comb begin
    sel_row = '0;
    for (int r = 0; r < ROWS; r++) begin
      row_sel[r] = (item.target_index == SIZE_W'(r));
      sel_row    = sel_row | (pixel_rows[r] & {COLUMNS{row_sel[r]}});
    end
  end

  // row rotated right with wrap-around
  assign row_dbl = {sel_row, sel_row} >> col_dist;
  assign rot_row = row_dbl[COLUMNS-1:0];

  // selected column as a vector over rows, rotated downward
  assign col_mask = COL_MSB >> item.target_index;
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      col_vec[r] = |(pixel_rows[r] & col_mask);
    end
  end
  assign col_dbl = {col_vec, col_vec} << row_dist;
  assign col_rot = col_dbl[2*ROWS-1:ROWS];

  // leftmost columns lit by a fill, saturates by itself past the width
  assign span = ~(FULL >> item.rect_width);

  // next pixel state
  always_comb begin
    rows_next = pixel_rows;
    case (item.command)
      CMD_FILL: begin
        for (int r = 0; r < ROWS; r++) begin
          if (item.rect_height > SIZE_W'(r)) begin
            rows_next[r] = pixel_rows[r] | span;
          end
        end
      end
      CMD_ROT_ROW: begin
        for (int r = 0; r < ROWS; r++) begin
          if (row_sel[r]) begin
            rows_next[r] = rot_row;
          end
        end
      end
      CMD_ROT_COL: begin
        if (col_ok) begin
          for (int r = 0; r < ROWS; r++) begin
            rows_next[r] = (pixel_rows[r] & ~col_mask) | (col_mask & {COLUMNS{col_rot[r]}});
          end
        end
      end
      default: begin
      end
    endcase
  end

  // error flag and read data
  always_comb begin
    case (item.command)
      CMD_ROT_ROW, CMD_READ_ROW: err_next = ~row_ok;
      CMD_ROT_COL:               err_next = ~col_ok;
      default:                   err_next = 1'b0;
    endcase
  end

  assign read_ext  = EXT_W'(sel_row);
  assign bits_next = (item.command == CMD_READ_ROW) ? read_ext[ROW_BITS_W-1:0] : '0;

  // pixel store
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_rows <= '0;
    end else if (en) begin
      pixel_rows <= rows_next;
    end
  end

  // result fields for this transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else if (advance) begin
      tag_valid <= en;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_err  <= err_next;
      tag_bits <= bits_next;
    end
  end

  assign tag = '{valid: tag_valid, err: tag_err, row_bits: tag_bits};

  // pixels only change when a command is applied
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pixel_rows))
    else $error("pixel store changed with no command applied");

  // a fill never reports an index error
  a_fill_no_err: assert property (@(posedge clk) disable iff (rst)
    en && item.command == CMD_FILL |=> tag_valid && !tag_err)
    else $error("fill raised index error");

  // only a read returns row data
  a_bits_read_only: assert property (@(posedge clk) disable iff (rst)
    en && item.command != CMD_READ_ROW |=> tag_bits == '0)
    else $error("row data on a non-read command");

endmodule

FILE: src/brfr_count.sv
module brfr_count #(
  parameter int COLUMNS = 50,
  parameter int ROWS    = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic [ROWS-1:0][COLUMNS-1:0]        pixel_rows,
  input  brfr_pkg::tag_t                      tag_in,
  output brfr_pkg::tag_t                      tag_out,
  output logic [brfr_pkg::LIT_W-1:0]          lit_count
);
  import brfr_pkg::*;

  localparam int ROW_CNT_W = $clog2(COLUMNS + 1);
  localparam int TOTAL     = ROWS * COLUMNS;
  localparam int SUM_W     = $clog2(TOTAL + 1);
  localparam int CMP_W     = (SUM_W > LIT_W) ? SUM_W : LIT_W;
  localparam int LIT_BOUND = (TOTAL < int'(LIT_MAX)) ? TOTAL : int'(LIT_MAX);

  logic [ROWS-1:0][ROW_CNT_W-1:0] row_cnt;
  logic                           mid_valid;
  logic                           mid_err;
  logic [ROW_BITS_W-1:0]          mid_bits;
  logic [SUM_W-1:0]               sum;
  logic [CMP_W-1:0]               sum_ext;
  logic [LIT_W-1:0]               lit_next;
  logic                           out_valid;
  logic                           out_err;
  logic [ROW_BITS_W-1:0]          out_bits;

  // per-row lit count of the state left by the previous stage
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < ROWS; r++) begin
        row_cnt[r] <= ROW_CNT_W'($countones(pixel_rows[r]));
      end
      mid_err  <= tag_in.err;
      mid_bits <= tag_in.row_bits;
    end
  end

  // total over rows, saturated to the field
  always_comb begin
    sum = '0;
    for (int r = 0; r < ROWS; r++) begin
      sum = sum + SUM_W'(row_cnt[r]);
    end
  end

  assign sum_ext  = CMP_W'(sum);
  assign lit_next = (sum_ext > CMP_W'(LIT_MAX)) ? LIT_MAX : sum_ext[LIT_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      lit_count <= lit_next;
      out_err   <= mid_err;
      out_bits  <= mid_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      mid_valid <= tag_in.valid;
      out_valid <= mid_valid;
    end
  end

  assign tag_out = '{valid: out_valid, err: out_err, row_bits: out_bits};

  // count never exceeds the display area or the field
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lit_count <= LIT_W'(LIT_BOUND))
    else $error("lit count above display area");

endmodule

FILE: src/bitmap_rect_fill_and_rotate.sv
// Monochrome frame store of ROWS by COLUMNS pixels, dark after reset, taking
// one command per transaction: fill the top-left rectangle, rotate a row right,
// rotate a column down, or read a row. Rotate distances wrap by the row or
// column length, an out-of-range index sets index_error and leaves the pixels
// alone, and every result carries the lit-pixel count after its command.
// A new command is accepted every cycle unless in_stall is high; the whole pixel
// array is updated in one register stage, which sets that rate. out_valid for a
// result rises after the command passes the pixel update, per-row count and
// total count registers behind the input register, later only while out_stall
// holds the pipeline.
module bitmap_rect_fill_and_rotate #(
  parameter int COLUMNS = 50,
  parameter int ROWS    = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  brfr_pkg::cmd_t                    command,
  input  logic [brfr_pkg::SIZE_W-1:0]       rect_width,
  input  logic [brfr_pkg::SIZE_W-1:0]       rect_height,
  input  logic [brfr_pkg::SIZE_W-1:0]       target_index,
  input  logic [brfr_pkg::DIST_W-1:0]       distance,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [brfr_pkg::LIT_W-1:0]        lit_count,
  output logic [brfr_pkg::ROW_BITS_W-1:0]   row_bits,
  output logic                              index_error
);
  import brfr_pkg::*;

  logic                         advance;
  logic                         item_valid;
  item_t                        item;
  logic [ROWS-1:0][COLUMNS-1:0] pixel_rows;
  tag_t                         exec_tag;
  tag_t                         out_tag;

  // whole pipeline moves unless a result is waiting on the output
  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = ~advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item <= '{command: command, rect_width: rect_width, rect_height: rect_height,
                target_index: target_index, distance: distance};
    end
  end

  brfr_exec #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item),
    .pixel_rows (pixel_rows),
    .tag        (exec_tag)
  );

  brfr_count #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_count (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .pixel_rows (pixel_rows),
    .tag_in     (exec_tag),
    .tag_out    (out_tag),
    .lit_count  (lit_count)
  );

  // result ports
  assign out_valid   = out_tag.valid;
  assign row_bits    = out_tag.row_bits;
  assign index_error = out_tag.err;

endmodule

FILE: tb/sv/bitmap_rect_fill_and_rotate_tb.sv
`timescale 1ns / 100ps

module bitmap_rect_fill_and_rotate_tb;
  import brfr_pkg::*;

  localparam int COLUMNS    = 50;
  localparam int ROWS       = 6;
  localparam int RANDOM_CMDS = 625;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [ROW_BITS_W-1:0] NO_BITS = '0;

  // one result as seen on the output side
  typedef struct {
    logic [LIT_W-1:0]      lit;
    logic [ROW_BITS_W-1:0] bits;
    logic                  err;
  } frame_result_t;

  // one row of the directed script; known marks a hand-written result
  typedef struct {
    cmd_t                  c;
    int                    w;
    int                    h;
    int                    idx;
    int                    amt;
    bit                    known;
    int                    lit;
    logic [ROW_BITS_W-1:0] bits;
    bit                    err;
  } script_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cmd_t                  command = CMD_FILL;
  logic [SIZE_W-1:0]     rect_width = '0;
  logic [SIZE_W-1:0]     rect_height = '0;
  logic [SIZE_W-1:0]     target_index = '0;
  logic [DIST_W-1:0]     distance = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LIT_W-1:0]      lit_count;
  logic [ROW_BITS_W-1:0] row_bits;
  logic                  index_error;

  // shadow copy of the pixel store, leftmost column in the top bit
  logic [COLUMNS-1:0] frame_rows [ROWS];
  frame_result_t      pending_results [$];
  int                 mismatches = 0;
  bit                 calm = 1'b0;

  // directed commands: errors and empty fills after reset, then rotations,
  // reads and the width and height extremes
  script_row_t script [25] = '{
    '{CMD_READ_ROW,  0,  0,  0,   0, 1'b1, 0, NO_BITS, 1'b0},
    '{CMD_READ_ROW,  0,  0, 63,   0, 1'b1, 0, NO_BITS, 1'b1},
    '{CMD_ROT_ROW,   0,  0,  6,   1, 1'b1, 0, NO_BITS, 1'b1},
    '{CMD_ROT_COL,   0,  0, 50,   1, 1'b1, 0, NO_BITS, 1'b1},
    '{CMD_ROT_COL,  63, 63, 63, 255, 1'b1, 0, NO_BITS, 1'b1},
    '{CMD_FILL,      0,  5,  0,   0, 1'b1, 0, NO_BITS, 1'b0},
    '{CMD_FILL,      7,  0,  0,   0, 1'b1, 0, NO_BITS, 1'b0},
    '{CMD_FILL,      3,  2,  0,   0, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_ROT_ROW,   0,  0,  0,   0, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_ROT_ROW,   0,  0,  0,  50, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_ROT_ROW,   0,  0,  1,  49, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_ROT_ROW,   0,  0,  1, 255, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_ROT_COL,   0,  0,  0,   6, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_ROT_COL,   0,  0, 49,   1, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_ROT_COL,   0,  0,  1, 255, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_READ_ROW,  0,  0,  0,   0, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_READ_ROW,  0,  0,  1,   0, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_FILL,     63,  1,  0,   0, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_FILL,      1, 63,  0,   0, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_FILL,     50,  0,  0,   0, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_FILL,      0,  6,  0,   0, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_ROT_ROW,   0,  0,  5, 200, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_READ_ROW,  0,  0,  5,   0, 1'b0, 0, NO_BITS, 1'b0},
    '{CMD_READ_ROW,  0,  0,  6,   0, 1'b0, 0, NO_BITS, 1'b1},
    '{CMD_READ_ROW,  0,  0,  0,   0, 1'b0, 0, NO_BITS, 1'b0}
  };

  bitmap_rect_fill_and_rotate #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .target_index(target_index),
    .distance    (distance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .lit_count   (lit_count),
    .row_bits    (row_bits),
    .index_error (index_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one command to the shadow frame and work out its result
  function automatic frame_result_t apply_command(cmd_t c, int w, int h, int idx, int amt);
    frame_result_t      res;
    logic [COLUMNS-1:0] snap [ROWS];
    logic [COLUMNS-1:0] v;
    int                 d;
    int                 total;
    res.lit  = '0;
    res.bits = '0;
    res.err  = 1'b0;
    case (c)
      CMD_FILL: begin
        if (w > COLUMNS) w = COLUMNS;
        if (h > ROWS) h = ROWS;
        for (int r = 0; r < h; r++)
          for (int k = 0; k < w; k++)
            frame_rows[r][COLUMNS-1-k] = 1'b1;
      end
      CMD_ROT_ROW: begin
        if (idx < ROWS) begin
          d = amt % COLUMNS;
          v = frame_rows[idx];
          if (d != 0) frame_rows[idx] = (v >> d) | (v << (COLUMNS - d));
        end else begin
          res.err = 1'b1;
        end
      end
      CMD_ROT_COL: begin
        if (idx < COLUMNS) begin
          d = amt % ROWS;
          snap = frame_rows;
          for (int r = 0; r < ROWS; r++)
            frame_rows[r][COLUMNS-1-idx] = snap[(r + ROWS - d) % ROWS][COLUMNS-1-idx];
        end else begin
          res.err = 1'b1;
        end
      end
      default: begin
        if (idx < ROWS) res.bits = ROW_BITS_W'(frame_rows[idx]);
        else res.err = 1'b1;
      end
    endcase
    total = 0;
    for (int r = 0; r < ROWS; r++) total += $countones(frame_rows[r]);
    res.lit = (total > int'(LIT_MAX)) ? LIT_MAX : LIT_W'(total);
    return res;
  endfunction

  // present one command, wait for its transaction, queue its result
  task automatic issue(cmd_t c, int w, int h, int idx, int amt, bit known,
                       frame_result_t known_res);
    frame_result_t want;
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= c;
    rect_width   <= SIZE_W'(w);
    rect_height  <= SIZE_W'(h);
    target_index <= SIZE_W'(idx);
    distance     <= DIST_W'(amt);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = apply_command(c, w, h, idx, amt);
    if (known) want = known_res;
    pending_results.push_back(want);
  endtask

  // hold off the sender until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // output side: compare each transaction, then pick the next stall
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result with none expected: lit_count %0d", lit_count);
      end else begin
        want = pending_results.pop_front();
        if (lit_count !== want.lit) begin
          mismatches++;
          $error("lit_count: expected %0d, got %0d", want.lit, lit_count);
        end
        if (row_bits !== want.bits) begin
          mismatches++;
          $error("row_bits: expected %h, got %h", want.bits, row_bits);
        end
        if (index_error !== want.err) begin
          mismatches++;
          $error("index_error: expected %0d, got %0d", want.err, index_error);
        end
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 13);
  end

  initial begin
    frame_result_t known_res;
    cmd_t          c;
    int            pick;
    int            w;
    int            h;
    int            idx;
    int            amt;
    foreach (frame_rows[r]) frame_rows[r] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed script
    foreach (script[i]) begin
      known_res.lit  = LIT_W'(script[i].lit);
      known_res.bits = script[i].bits;
      known_res.err  = script[i].err;
      issue(script[i].c, script[i].w, script[i].h, script[i].idx, script[i].amt,
            script[i].known, known_res);
    end
    drain_results();

    // random commands, mostly rotations so the frame stays far from full
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      calm = (i >= 200 && i < 360);
      if (i == 300) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 10) c = CMD_FILL;
      else if (pick < 42) c = CMD_ROT_ROW;
      else if (pick < 74) c = CMD_ROT_COL;
      else c = CMD_READ_ROW;
      w    = $urandom_range(0, 4);
      h    = $urandom_range(0, 2);
      amt  = $urandom_range(0, 255);
      if (c == CMD_FILL && i > 580 && $urandom_range(0, 3) == 0) begin
        w = $urandom_range(0, 63);
        h = $urandom_range(0, 63);
      end else if ($urandom_range(0, 9) == 0) begin
        // sizes are don't-care for non-fill commands, so exercise every bit
        if (c != CMD_FILL) begin
          w = $urandom_range(0, 63);
          h = $urandom_range(0, 63);
        end
      end
      if (c == CMD_ROT_COL)
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(COLUMNS, 63)
                                         : $urandom_range(0, COLUMNS - 1);
      else
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(ROWS, 63)
                                         : $urandom_range(0, ROWS - 1);
      issue(c, w, h, idx, amt, 1'b0, known_res);
    end
    calm = 1'b0;

    // let the pipeline empty, then watch for strays
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
